// ===== hw/rtl/lgsp_pkg.sv =====
// shared types, action codes and constants for the light gun sensor port
package lgsp_pkg;

  // action codes
  localparam logic [2:0] ACT_AIM      = 3'd0;
  localparam logic [2:0] ACT_TRIG_ON  = 3'd1;
  localparam logic [2:0] ACT_TRIG_OFF = 3'd2;
  localparam logic [2:0] ACT_FRAME    = 3'd3;
  localparam logic [2:0] ACT_PORT_RD  = 3'd4;
  localparam logic [2:0] ACT_STROBE   = 3'd5;
  localparam logic [2:0] ACT_SER_RD   = 3'd6;

  // register indexes
  localparam logic REG_WINDOW_LINES = 1'b0;
  localparam logic REG_PULL_FRAMES  = 1'b1;

  // register reset values
  localparam logic [7:0] WINDOW_LINES_RST = 8'd25;
  localparam logic [2:0] PULL_FRAMES_RST  = 3'd2;

  // palette brightness test constants
  localparam logic [3:0] LUMA_DARK_MIN = 4'he;
  localparam logic [1:0] HUE_BAND_MIN  = 2'd2;

  // one request as held in the input stage
  typedef struct packed {
    logic [2:0] action;
    logic       pressed;
    logic [7:0] aim_x_in;
    logic [7:0] aim_y_in;
    logic [8:0] beam_line;
    logic [8:0] beam_dot;
    logic [5:0] aim_color;
    logic       strobe_bit;
    logic       serial_port;
  } item_t;

  // configuration registers
  typedef struct packed {
    logic [7:0] window_lines;
    logic [2:0] pull_frames;
  } cfg_t;

  // bright palette entry: low nibble below 0xe, upper bits at least 2
  function automatic logic is_bright(input logic [5:0] color);
    is_bright = (color[3:0] < LUMA_DARK_MIN) && (color[5:4] >= HUE_BAND_MIN);
  endfunction

endpackage

// ===== hw/rtl/lgsp_core.sv =====
// gun state registers and per-request evaluation
module lgsp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  lgsp_pkg::item_t   item,
  input  lgsp_pkg::cfg_t    cfg,
  output logic [7:0]        read_data
);

  logic [7:0] aim_col_r,      aim_col_nxt;
  logic [7:0] aim_row_r,      aim_row_nxt;
  logic [2:0] pull_count_r,   pull_count_nxt;
  logic       pull_active_r,  pull_active_nxt;
  logic       off_screen_r,   off_screen_nxt;
  logic       strobe_level_r, strobe_level_nxt;
  logic [7:0] serial_latch_r, serial_latch_nxt;

  logic [8:0] row9;
  logic [8:0] col9;
  logic [8:0] last_line;
  logic       in_window;
  logic       light;
  logic [7:0] port_byte;

  // sensor window from aim point to window_lines lines further
  assign row9      = {1'b0, aim_row_r};
  assign col9      = {1'b0, aim_col_r};
  assign last_line = row9 + {1'b0, cfg.window_lines};
  assign in_window = (item.beam_line >= row9) && (item.beam_line <= last_line)
                   && !((item.beam_line == row9) && (item.beam_dot < col9))
                   && !((item.beam_line == last_line) && (item.beam_dot > col9));
  assign light     = in_window && !off_screen_r && lgsp_pkg::is_bright(item.aim_color);
  assign port_byte = {3'b000, pull_active_r, !light, 3'b000};

  // next state and result
  always_comb begin
    aim_col_nxt      = aim_col_r;
    aim_row_nxt      = aim_row_r;
    pull_count_nxt   = pull_count_r;
    pull_active_nxt  = pull_active_r;
    off_screen_nxt   = off_screen_r;
    strobe_level_nxt = strobe_level_r;
    serial_latch_nxt = serial_latch_r;
    read_data        = 8'h00;
    case (item.action)
      lgsp_pkg::ACT_AIM: begin
        aim_col_nxt = item.aim_x_in;
        aim_row_nxt = item.aim_y_in;
      end
      lgsp_pkg::ACT_TRIG_ON, lgsp_pkg::ACT_TRIG_OFF: begin
        if (item.pressed && !pull_active_r) begin
          off_screen_nxt  = (item.action == lgsp_pkg::ACT_TRIG_OFF);
          pull_count_nxt  = cfg.pull_frames;
          pull_active_nxt = 1'b1;
        end
      end
      lgsp_pkg::ACT_FRAME: begin
        if (pull_active_r) begin
          if (pull_count_r == 3'd0) pull_active_nxt = 1'b0;
          else                      pull_count_nxt  = pull_count_r - 3'd1;
        end
      end
      lgsp_pkg::ACT_PORT_RD: begin
        read_data = port_byte;
      end
      lgsp_pkg::ACT_STROBE: begin
        if (!strobe_level_r && item.strobe_bit) begin
          strobe_level_nxt = 1'b1;
        end else if (strobe_level_r && !item.strobe_bit) begin
          // falling strobe: trigger in bit 7, light in bit 6, connected in bit 4
          strobe_level_nxt = 1'b0;
          serial_latch_nxt = {pull_active_r, light, 1'b0, 1'b1, 4'h0};
        end
      end
      lgsp_pkg::ACT_SER_RD: begin
        if (!item.serial_port) begin
          read_data        = {7'd0, serial_latch_r[0]};
          serial_latch_nxt = {1'b1, serial_latch_r[7:1]};
        end
      end
      default: begin
      end
    endcase
  end

  // state registers, updated as each request leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aim_col_r      <= 8'd0;
      aim_row_r      <= 8'd0;
      pull_count_r   <= 3'd0;
      pull_active_r  <= 1'b0;
      off_screen_r   <= 1'b0;
      strobe_level_r <= 1'b0;
      serial_latch_r <= 8'd0;
    end else if (fire) begin
      aim_col_r      <= aim_col_nxt;
      aim_row_r      <= aim_row_nxt;
      pull_count_r   <= pull_count_nxt;
      pull_active_r  <= pull_active_nxt;
      off_screen_r   <= off_screen_nxt;
      strobe_level_r <= strobe_level_nxt;
      serial_latch_r <= serial_latch_nxt;
    end
  end

`ifndef ASSERT_OFF
  // trigger goes idle only from a zero count
  a_idle_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(pull_active_r) |-> $past(pull_count_r) == 3'd0)
    else $error("trigger went idle with nonzero count");

  // state holds while no request is processed
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(fire) && $past(rst_n) |-> $stable(serial_latch_r) && $stable(pull_active_r))
    else $error("state changed without a request");

  // a new latch always carries the connected bit
  a_latch_connected: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(strobe_level_r) |-> serial_latch_r[4] && !serial_latch_r[5])
    else $error("latched byte malformed");
`endif

endmodule

// ===== hw/rtl/light_gun_sensor_port.sv =====
// top level of the light gun sensor port: request stages and register port
//
//  channel   direction  handshake            payload
//  in_       request    in_valid / in_stall  action, pressed, aim, beam, colour, strobe, port
//  out_      result     out_valid/out_stall  read_data
//  apb       config     psel/penable/pready  paddr[2:0], pwdata, prdata
//
// one request per cycle unless stalled: input register, then state update, result register
// a result is registered as its request leaves the input register, and the gun state
// updates as that request moves from the input register to the result register
// synchronous active-low reset empties both stages, clears gun state, presets registers
// out_stall holds the result register, and the input register fills behind it
module light_gun_sensor_port (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic        in_pressed,
  input  logic [7:0]  in_aim_x_in,
  input  logic [7:0]  in_aim_y_in,
  input  logic [8:0]  in_beam_line,
  input  logic [8:0]  in_beam_dot,
  input  logic [5:0]  in_aim_color,
  input  logic        in_strobe_bit,
  input  logic        in_serial_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lgsp_pkg::cfg_t  cfg_r;
  lgsp_pkg::item_t s1_item_r;
  logic            s1_vld_r;
  logic            out_vld_r;
  logic [7:0]      out_data_r;
  logic [7:0]      core_data;
  logic            out_free;
  logic            fire;
  logic            in_take;
  logic            cfg_wr;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_lines <= lgsp_pkg::WINDOW_LINES_RST;
      cfg_r.pull_frames  <= lgsp_pkg::PULL_FRAMES_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        lgsp_pkg::REG_WINDOW_LINES: cfg_r.window_lines <= pwdata[7:0];
        lgsp_pkg::REG_PULL_FRAMES:  cfg_r.pull_frames  <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (paddr[2])
      lgsp_pkg::REG_WINDOW_LINES: prdata = {24'd0, cfg_r.window_lines};
      lgsp_pkg::REG_PULL_FRAMES:  prdata = {29'd0, cfg_r.pull_frames};
      default:                    prdata = 32'd0;
    endcase
  end

  // stage control
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.action      <= in_action;
      s1_item_r.pressed     <= in_pressed;
      s1_item_r.aim_x_in    <= in_aim_x_in;
      s1_item_r.aim_y_in    <= in_aim_y_in;
      s1_item_r.beam_line   <= in_beam_line;
      s1_item_r.beam_dot    <= in_beam_dot;
      s1_item_r.aim_color   <= in_aim_color;
      s1_item_r.strobe_bit  <= in_strobe_bit;
      s1_item_r.serial_port <= in_serial_port;
    end
  end

  // gun state and evaluation
  lgsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .read_data (core_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= core_data;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_read_data = out_data_r;

`ifndef ASSERT_OFF
  // input side stalls only behind a full input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty stage");

  // a new result comes only from a held request
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_vld_r))
    else $error("result appeared without a request");

  // an unblocked result register drains the input register
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_vld_r && !in_valid |=> !s1_vld_r && out_vld_r)
    else $error("request stuck in input stage");
`endif

endmodule
